// ===== rtl/pfe_pkg.sv =====
// Shared types and constants of the printf format expander.
`timescale 1ns / 1ps
package pfe_pkg;

  localparam logic [1:0] ACT_FORMAT = 2'd0;
  localparam logic [1:0] ACT_STRING = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X_LO    = 8'h78;
  localparam logic [7:0] CH_X_UP    = 8'h58;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LO    = 8'h61;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam int ARG_BITS    = 32;
  localparam int DEC_DIGITS  = 10;
  localparam int HEX_DIGITS  = 8;
  localparam int DIG_IDX_W   = $clog2(DEC_DIGITS);
  localparam int DIG_LEN_W   = $clog2(DEC_DIGITS + 1);
  localparam int HEX_CNT_W   = $clog2(HEX_DIGITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int TOTAL_BITS  = 16;

  localparam logic [ARG_BITS-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int DEC_SHIFT = 35;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_DEC,
    CMD_HEX,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [7:0]          chr;
    logic [ARG_BITS-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_DEC_OUT,
    B_HEX_0,
    B_HEX_X,
    B_HEX_DIG
  } back_state_t;

endpackage

// ===== rtl/pfe_front.sv =====
// Front end: accepts input items, tracks the armed flag and queues requests.
`timescale 1ns / 1ps
module pfe_front import pfe_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [7:0]          data_byte,
  input  logic [ARG_BITS-1:0] arg_value,
  input  logic                q_full,
  output logic                push,
  output cmd_t                push_cmd
);

  localparam int VAL_BITS = (WORD_BITS < ARG_BITS) ? WORD_BITS : ARG_BITS;
  localparam logic [ARG_BITS-1:0] ARG_MASK = ARG_BITS'((64'd1 << VAL_BITS) - 64'd1);

  logic                after_percent;
  logic                after_percent_next;
  logic                want_push;
  logic                accept;
  logic [ARG_BITS-1:0] arg_m;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign arg_m    = arg_value & ARG_MASK;
  assign push     = accept && want_push;

  always_comb begin
    want_push          = 1'b0;
    after_percent_next = after_percent;
    push_cmd.kind      = CMD_BYTE;
    push_cmd.chr       = data_byte;
    push_cmd.value     = arg_m;
    case (action)
      ACT_FORMAT: begin
        if (!after_percent) begin
          if (data_byte == CH_PERCENT) begin
            after_percent_next = 1'b1;
          end else begin
            want_push = 1'b1;
          end
        end else begin
          after_percent_next = 1'b0;
          case (data_byte)
            CH_C: begin
              want_push    = 1'b1;
              push_cmd.chr = arg_m[7:0];
            end
            CH_D, CH_U: begin
              want_push     = 1'b1;
              push_cmd.kind = CMD_DEC;
            end
            CH_X_LO, CH_X_UP: begin
              want_push     = 1'b1;
              push_cmd.kind = CMD_HEX;
            end
            default: begin
            end
          endcase
        end
      end
      ACT_STRING: begin
        want_push = 1'b1;
      end
      ACT_FINISH: begin
        want_push          = 1'b1;
        push_cmd.kind      = CMD_FINISH;
        after_percent_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_percent <= 1'b0;
    end else if (accept) begin
      after_percent <= after_percent_next;
    end
  end

endmodule

// ===== rtl/pfe_queue.sv =====
// Short request queue between front and back ends.
`timescale 1ns / 1ps
module pfe_queue import pfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/pfe_back.sv =====
// Back end: carries out queued requests and drives the output register.
`timescale 1ns / 1ps
module pfe_back import pfe_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  last,
  output logic [TOTAL_BITS-1:0] total_length
);

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  back_state_t            state;
  back_state_t            state_next;
  logic [ARG_BITS-1:0]    val;
  logic [DIG_LEN_W-1:0]   len;
  logic [DIG_LEN_W-1:0]   len_m1;
  logic [3:0]             digits [DEC_DIGITS];
  logic [HEX_CNT_W-1:0]   hexcnt;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [31:0]            count_wide;

  logic [63:0]            prod;
  logic [ARG_BITS-1:0]    quot;
  logic [ARG_BITS-1:0]    rem_full;

  logic       slot_free;
  logic       emit;
  logic [7:0] emit_chr;
  logic       emit_last;
  logic       emit_fin;
  logic       div_step;
  logic       dec_step;
  logic       hex_step;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? CH_ZERO + {4'd0, n} : CH_A_LO + {4'd0, n} - 8'd10;
  endfunction

  assign slot_free  = !out_valid || !out_stall;
  assign prod       = 64'(val) * 64'(DEC_RECIP);
  assign quot       = ARG_BITS'(prod[63:DEC_SHIFT]);
  assign rem_full   = val - (quot << 3) - (quot << 1);
  assign len_m1     = len - 1'b1;
  assign count_inc  = (count == CNT_MAX) ? count : count + 1'b1;
  assign count_wide = 32'(count_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_chr   = CH_NUL;
    emit_last  = 1'b0;
    emit_fin   = 1'b0;
    div_step   = 1'b0;
    dec_step   = 1'b0;
    hex_step   = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_BYTE: begin
              if (slot_free) begin
                pop       = 1'b1;
                emit      = 1'b1;
                emit_chr  = q_cmd.chr;
                emit_last = 1'b1;
              end
            end
            CMD_FINISH: begin
              if (slot_free) begin
                pop       = 1'b1;
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_fin  = 1'b1;
              end
            end
            CMD_DEC: begin
              pop        = 1'b1;
              state_next = B_DIV;
            end
            CMD_HEX: begin
              pop        = 1'b1;
              state_next = B_HEX_0;
            end
            default: begin
            end
          endcase
        end
      end
      B_DIV: begin
        div_step = 1'b1;
        if (quot == '0) begin
          state_next = B_DEC_OUT;
        end
      end
      B_DEC_OUT: begin
        if (slot_free) begin
          emit      = 1'b1;
          dec_step  = 1'b1;
          emit_chr  = CH_ZERO + {4'd0, digits[len_m1[DIG_IDX_W-1:0]]};
          emit_last = (len == DIG_LEN_W'(1));
          if (len == DIG_LEN_W'(1)) begin
            state_next = B_IDLE;
          end
        end
      end
      B_HEX_0: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_chr   = CH_ZERO;
          state_next = B_HEX_X;
        end
      end
      B_HEX_X: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_chr   = CH_X_LO;
          state_next = B_HEX_DIG;
        end
      end
      B_HEX_DIG: begin
        if (slot_free) begin
          emit      = 1'b1;
          hex_step  = 1'b1;
          emit_chr  = hex_char(val[ARG_BITS-1 -: 4]);
          emit_last = (hexcnt == HEX_CNT_W'(HEX_DIGITS - 1));
          if (hexcnt == HEX_CNT_W'(HEX_DIGITS - 1)) begin
            state_next = B_IDLE;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      val    <= q_cmd.value;
      len    <= '0;
      hexcnt <= '0;
    end else if (div_step) begin
      digits[len[DIG_IDX_W-1:0]] <= rem_full[3:0];
      len                        <= len + 1'b1;
      val                        <= quot;
    end else if (dec_step) begin
      len <= len_m1;
    end else if (hex_step) begin
      val    <= val << 4;
      hexcnt <= hexcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (emit) begin
      count <= emit_fin ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte     <= emit_chr;
      last         <= emit_last;
      total_length <= emit_fin ? count_wide[TOTAL_BITS-1:0] : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) emit |-> slot_free)
    else $error("result issued while output register is occupied");
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty request queue");
  assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (len < DIG_LEN_W'(DEC_DIGITS)))
    else $error("decimal digit buffer overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state == B_DEC_OUT) |-> (len != '0))
    else $error("decimal output with empty digit buffer");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (total_length != '0)) |-> last)
    else $error("length reported on a result that is not last");

endmodule

// ===== rtl/printf_format_expander.sv =====
// Top level of the printf format expander.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries action, data_byte and
//   arg_value; a request is taken when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall) carries the characters of each
//   request in out_byte, with last on the final character of each input
//   request and total_length on the finish character.
//   The front end classifies each request and places work in a two-entry
//   queue; the back end expands it into characters, one request at a time.
//   A copied byte is registered in a queue entry, then in the output register.
//   Throughput: copied bytes and finish run at one per cycle while the
//   output is not stalled; a hex conversion loads the value, then sends
//   ten characters ('0', 'x', digits); a decimal conversion loads it, then
//   the divide-by-ten unit produces one digit per cycle before the digits
//   are sent most significant first. Requests that produce no output
//   (the armed '%', 's', unknown conversions) never reach the queue.
//   Reset clears the armed flag, the byte count, the queue and out_valid.
//   A stall on the output holds the output register; the back end then
//   waits, the queue fills and in_stall rises.
module printf_format_expander import pfe_pkg::*; #(
  parameter int WORD_BITS   = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [7:0]            data_byte,
  input  logic [ARG_BITS-1:0]   arg_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  last,
  output logic [TOTAL_BITS-1:0] total_length
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  pfe_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .data_byte (data_byte),
    .arg_value (arg_value),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  pfe_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last         (last),
    .total_length (total_length)
  );

endmodule
